@@ sv/nbp_pkg.sv @@
// nbp_pkg: shared constants for the node boundary point block
// used by node_boundary_point and nbp_check; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nbp_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_CLEARANCE = 3'd0;
  localparam logic [7:0] MARGIN_RESET = 8'd2;

endpackage

`default_nettype wire

@@ sv/node_boundary_point.sv @@
// node_boundary_point: point where the ray from a node center leaves its outline
// depends on nbp_pkg, nbp_div, nbp_sqrt
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall | mode, ellipse_shape, center, size, other
//   output  | out       | out_valid/out_stall | boundary_x, boundary_y
//   config  | in        | apb, pready high    | clearance at address 0
//
// one item per cycle while out_stall does not hold the pipeline; the result passes
// through two divider and two square root pipelines in series, one bit per stage
// synchronous reset clears all valid bits and sets the clearance to 2
// a stalled result freezes the whole pipeline; in_stall is high while it waits
`timescale 1ns / 1ps
`default_nettype none

module node_boundary_point #(
  parameter int FRACTION_BITS = nbp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nbp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        mode,
  input  wire logic                        ellipse_shape,
  input  wire logic signed [15:0]          center_x,
  input  wire logic signed [15:0]          center_y,
  input  wire logic [14:0]                 node_width,
  input  wire logic [14:0]                 node_height,
  input  wire logic signed [15:0]          other_x,
  input  wire logic signed [15:0]          other_y,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [15:0]               boundary_x,
  output logic signed [15:0]               boundary_y
);

  localparam int F = FRACTION_BITS;
  localparam int AW = F + 14;
  localparam int NW1 = 2 * F + 32;
  localparam int DW1 = 33;
  localparam int VW1 = 2 * F + 2;
  localparam int RW1 = F + 1;
  localparam int VW2 = 2 * AW + 2;
  localparam int RW2 = AW + 1;
  localparam int NW2 = 2 * AW;
  localparam int PW = 33 + RW1;
  localparam int LO = ((1 << F) + 5) / 10;
  localparam logic [32:0] HALF = 33'(1) << (F - 1);

  typedef struct packed {
    logic          use_ell;
    logic          pz;
    logic          qz;
    logic          take_y;
    logic          negx;
    logic          negy;
    logic [15:0]   cx;
    logic [15:0]   cy;
    logic [15:0]   ex;
    logic [15:0]   ey;
    logic          aeqb;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [NW2-1:0] ab;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [15:0] rq;
  } side1_t;

  typedef struct packed {
    side1_t       t1;
    logic [RW1-1:0] cr;
    logic [RW1-1:0] sr;
  } side2_t;

  logic en;
  logic [7:0] margin;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign pready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= nbp_pkg::MARGIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == nbp_pkg::ADDR_CLEARANCE) begin
      margin <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == nbp_pkg::ADDR_CLEARANCE) ? {24'd0, margin} : 32'd0;

  // input register
  logic        v0, mode0, ell0;
  logic [15:0] cx0, cy0, ox0, oy0;
  logic [14:0] w0, h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      mode0 <= mode;
      ell0 <= ellipse_shape;
      cx0 <= center_x;
      cy0 <= center_y;
      ox0 <= other_x;
      oy0 <= other_y;
      w0 <= node_width;
      h0 <= node_height;
    end
  end

  // offsets, half extents, ellipse axes
  logic [16:0]   dx, dy, adx, ady;
  logic [AW-1:0] a_raw, b_raw;
  assign dx = {ox0[15], ox0} - {cx0[15], cx0};
  assign dy = {oy0[15], oy0} - {cy0[15], cy0};
  assign adx = dx[16] ? (~dx + 17'd1) : dx;
  assign ady = dy[16] ? (~dy + 17'd1) : dy;
  assign a_raw = {w0, {(F-1){1'b0}}};
  assign b_raw = {h0, {(F-1){1'b0}}};

  logic          v1, use1, pz1, qz1, negx1, negy1;
  logic [15:0]   p1, q1, ex1, ey1, cx1, cy1;
  logic [14:0]   w1, h1;
  logic [AW-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      p1 <= adx[15:0];
      q1 <= ady[15:0];
      pz1 <= adx == 17'd0;
      qz1 <= ady == 17'd0;
      use1 <= mode0 && ell0 && adx != 17'd0 && ady != 17'd0;
      negx1 <= $signed(ox0) <= $signed(cx0);
      negy1 <= $signed(oy0) < $signed(cy0);
      ex1 <= 16'(w0[14:1]) + (mode0 ? 16'd0 : 16'(margin));
      ey1 <= 16'(h0[14:1]) + (mode0 ? 16'd0 : 16'(margin));
      cx1 <= cx0;
      cy1 <= cy0;
      w1 <= w0;
      h1 <= h0;
      a1 <= (a_raw < AW'(LO)) ? AW'(LO) : a_raw;
      b1 <= (b_raw < AW'(LO)) ? AW'(LO) : b_raw;
    end
  end

  // products
  logic           v2, use2, pz2, qz2, negx2, negy2, hz2;
  logic [15:0]    p2, q2, ex2, ey2, cx2, cy2;
  logic [31:0]    pp2, qq2, ph2, wq2, pey2, qex2;
  logic [AW-1:0]  a2, b2;
  logic [NW2-1:0] ab2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      pp2 <= 32'(p1) * 32'(p1);
      qq2 <= 32'(q1) * 32'(q1);
      ph2 <= 32'(p1) * 32'(h1);
      wq2 <= 32'(w1) * 32'(q1);
      pey2 <= 32'(p1) * 32'(ey1);
      qex2 <= 32'(q1) * 32'(ex1);
      ab2 <= NW2'(a1) * NW2'(b1);
      hz2 <= h1 == 15'd0;
      use2 <= use1;
      pz2 <= pz1;
      qz2 <= qz1;
      negx2 <= negx1;
      negy2 <= negy1;
      p2 <= p1;
      q2 <= q1;
      ex2 <= ex1;
      ey2 <= ey1;
      cx2 <= cx1;
      cy2 <= cy1;
      a2 <= a1;
      b2 <= b1;
    end
  end

  // branch choice and divider operands
  logic           take_y2;
  logic           v3;
  side_t          sd3;
  logic [NW1-1:0] rn3, cn3, sn3;
  logic [DW1-1:0] rd3, l23;

  assign take_y2 = hz2 || ph2 < wq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      rn3 <= take_y2 ? NW1'(pey2) : NW1'(qex2);
      rd3 <= take_y2 ? DW1'(q2) : DW1'(p2);
      cn3 <= {pp2, {(2*F){1'b0}}};
      sn3 <= {qq2, {(2*F){1'b0}}};
      l23 <= DW1'(pp2) + DW1'(qq2);
      sd3.use_ell <= use2;
      sd3.pz <= pz2;
      sd3.qz <= qz2;
      sd3.take_y <= take_y2;
      sd3.negx <= negx2;
      sd3.negy <= negy2;
      sd3.cx <= cx2;
      sd3.cy <= cy2;
      sd3.ex <= ex2;
      sd3.ey <= ey2;
      sd3.aeqb <= a2 == b2;
      sd3.a <= a2;
      sd3.b <= b2;
      sd3.ab <= ab2;
    end
  end

  // rectangle quotient and squared cosine, sine
  logic           vd1;
  logic [NW1-1:0] rq_full, cq_full, sq_full;
  logic [$bits(side_t)-1:0] tag_d1;

  nbp_div #(.NW(NW1), .DW(DW1), .SW($bits(side_t))) u_div_rect (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_num(rn3), .in_den(rd3), .in_tag(sd3),
    .out_valid(vd1), .out_quo(rq_full), .out_tag(tag_d1)
  );

  nbp_div #(.NW(NW1), .DW(DW1), .SW(1)) u_div_cos (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_num(cn3), .in_den(l23), .in_tag(1'b0),
    .out_valid(), .out_quo(cq_full), .out_tag()
  );

  nbp_div #(.NW(NW1), .DW(DW1), .SW(1)) u_div_sin (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_num(sn3), .in_den(l23), .in_tag(1'b0),
    .out_valid(), .out_quo(sq_full), .out_tag()
  );

  side1_t sd_d1;
  assign sd_d1.sd = side_t'(tag_d1);
  assign sd_d1.rq = rq_full[15:0];

  logic           vs1;
  logic [RW1-1:0] c_root, s_root;
  logic [$bits(side1_t)-1:0] tag_s1;

  nbp_sqrt #(.VW(VW1), .SW($bits(side1_t))) u_sqrt_cos (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vd1), .in_val({1'b0, cq_full[2*F:0]}), .in_tag(sd_d1),
    .out_valid(vs1), .out_root(c_root), .out_tag(tag_s1)
  );

  nbp_sqrt #(.VW(VW1), .SW(1)) u_sqrt_sin (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vd1), .in_val({1'b0, sq_full[2*F:0]}), .in_tag(1'b0),
    .out_valid(), .out_root(s_root), .out_tag()
  );

  side2_t sd_s1;
  assign sd_s1.t1 = side1_t'(tag_s1);
  assign sd_s1.cr = c_root;
  assign sd_s1.sr = s_root;

  // ellipse radius denominator
  logic              v4, v5, v6;
  side2_t            sd4, sd5, sd6;
  logic [AW+RW1-1:0] asp4, bcp4;
  logic [2*AW-1:0]   asq5, bsq5;
  logic [2*AW:0]     sum6;
  logic [AW-1:0]     as4, bc4;

  assign as4 = asp4[F+AW-1:F];
  assign bc4 = bcp4[F+AW-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= vs1;
      v5 <= v4;
      v6 <= v5;
    end
    if (en) begin
      sd4 <= sd_s1;
      asp4 <= (AW+RW1)'(sd_s1.t1.sd.a) * (AW+RW1)'(sd_s1.sr);
      bcp4 <= (AW+RW1)'(sd_s1.t1.sd.b) * (AW+RW1)'(sd_s1.cr);
      sd5 <= sd4;
      asq5 <= (2*AW)'(as4) * (2*AW)'(as4);
      bsq5 <= (2*AW)'(bc4) * (2*AW)'(bc4);
      sd6 <= sd5;
      sum6 <= (2*AW+1)'(asq5) + (2*AW+1)'(bsq5);
    end
  end

  logic           vs2;
  logic [RW2-1:0] d_root, d_den;
  logic [$bits(side2_t)-1:0] tag_s2;

  nbp_sqrt #(.VW(VW2), .SW($bits(side2_t))) u_sqrt_den (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .in_val({1'b0, sum6}), .in_tag(sd6),
    .out_valid(vs2), .out_root(d_root), .out_tag(tag_s2)
  );

  side2_t sd_s2;
  assign sd_s2 = side2_t'(tag_s2);
  assign d_den = (d_root == '0) ? RW2'(1) : d_root;

  logic           vd2;
  logic [NW2-1:0] r_quo;
  logic [$bits(side2_t)-1:0] tag_d2;

  nbp_div #(.NW(NW2), .DW(RW2), .SW($bits(side2_t))) u_div_rad (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vs2), .in_num(sd_s2.t1.sd.ab), .in_den(d_den), .in_tag(sd_s2),
    .out_valid(vd2), .out_quo(r_quo), .out_tag(tag_d2)
  );

  side2_t      sd_d2;
  logic [31:0] r_sat;
  assign sd_d2 = side2_t'(tag_d2);
  assign r_sat = sd_d2.t1.sd.aeqb ? 32'(sd_d2.t1.sd.a) :
                 (|r_quo[NW2-1:32]) ? 32'hFFFF_FFFF : r_quo[31:0];

  // radius plus one half for rounding, projection
  logic          v7, v8;
  side2_t        sd7, sd8;
  logic [32:0]   r7;
  logic [PW-1:0] rc8, rs8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v7 <= vd2;
      v8 <= v7;
    end
    if (en) begin
      sd7 <= sd_d2;
      r7 <= 33'(r_sat) + HALF;
      sd8 <= sd7;
      rc8 <= PW'(r7) * PW'(sd7.cr);
      rs8 <= PW'(r7) * PW'(sd7.sr);
    end
  end

  // final selection and signs
  logic [15:0] bx8, by8, xo8, yo8;
  side_t       sf8;
  assign sf8 = sd8.t1.sd;

  always_comb begin
    if (sf8.use_ell) begin
      bx8 = rc8[2*F+15:2*F];
      by8 = rs8[2*F+15:2*F];
    end else if (sf8.qz) begin
      bx8 = sf8.ex;
      by8 = 16'd0;
    end else if (sf8.pz) begin
      bx8 = 16'd0;
      by8 = sf8.ey;
    end else if (sf8.take_y) begin
      bx8 = sd8.t1.rq;
      by8 = sf8.ey;
    end else begin
      bx8 = sf8.ex;
      by8 = sd8.t1.rq;
    end
  end

  assign xo8 = sf8.negx ? (16'd0 - bx8) : bx8;
  assign yo8 = sf8.negy ? (16'd0 - by8) : by8;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
    if (en) begin
      boundary_x <= sf8.cx + xo8;
      boundary_y <= sf8.cy + yo8;
    end
  end

endmodule

`default_nettype wire

@@ sv/nbp_div.sv @@
// nbp_div: pipelined restoring divider, one quotient bit per stage
// carries a valid bit and a tag alongside; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nbp_div #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_tag,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_tag
);

  logic          vld_s [0:NW];
  logic [NW-1:0] num_s [0:NW];
  logic [DW-1:0] rem_s [0:NW];
  logic [NW-1:0] quo_s [0:NW];
  logic [DW-1:0] den_s [0:NW];
  logic [SW-1:0] tag_s [0:NW];

  assign vld_s[0] = in_valid;
  assign num_s[0] = in_num;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign den_s[0] = in_den;
  assign tag_s[0] = in_tag;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_s[k], num_s[k][NW-1]};
    assign ge = trial >= {1'b0, den_s[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
      if (en) begin
        num_s[k+1] <= num_s[k] << 1;
        rem_s[k+1] <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
        quo_s[k+1] <= {quo_s[k][NW-2:0], ge};
        den_s[k+1] <= den_s[k];
        tag_s[k+1] <= tag_s[k];
      end
    end
  end

  assign out_valid = vld_s[NW];
  assign out_quo = quo_s[NW];
  assign out_tag = tag_s[NW];

endmodule

`default_nettype wire

@@ sv/nbp_sqrt.sv @@
// nbp_sqrt: pipelined floor square root, one root bit per stage
// carries a valid bit and a tag alongside; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nbp_sqrt #(
  parameter int VW = 18,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [VW-1:0] in_val,
  input  wire logic [SW-1:0] in_tag,
  output logic               out_valid,
  output logic [VW/2-1:0]    out_root,
  output logic [SW-1:0]      out_tag
);

  localparam int RW = VW / 2;

  logic          vld_s  [0:RW];
  logic [VW-1:0] val_s  [0:RW];
  logic [RW+1:0] rem_s  [0:RW];
  logic [RW-1:0] root_s [0:RW];
  logic [SW-1:0] tag_s  [0:RW];

  assign vld_s[0] = in_valid;
  assign val_s[0] = in_val;
  assign rem_s[0] = '0;
  assign root_s[0] = '0;
  assign tag_s[0] = in_tag;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] trial;
    logic [RW+3:0] t;
    logic          ge;
    assign trial = {rem_s[k], val_s[k][VW-1:VW-2]};
    assign t = (RW+4)'({root_s[k], 2'b01});
    assign ge = trial >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
      if (en) begin
        val_s[k+1] <= val_s[k] << 2;
        rem_s[k+1] <= ge ? (RW+2)'(trial - t) : trial[RW+1:0];
        root_s[k+1] <= {root_s[k][RW-2:0], ge};
        tag_s[k+1] <= tag_s[k];
      end
    end
  end

  assign out_valid = vld_s[RW];
  assign out_root = root_s[RW];
  assign out_tag = tag_s[RW];

endmodule

`default_nettype wire

@@ sv/nbp_check.sv @@
// nbp_check: port-level assertions for node_boundary_point
// depends on nbp_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module nbp_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [nbp_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [15:0]                 boundary_x,
  input wire logic [15:0]                 boundary_y
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(boundary_x) && $stable(boundary_y))
    else $error("stalled result changed");

  // a waiting result blocks new items
  a_back: assert property (@(posedge clk)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == nbp_pkg::ADDR_CLEARANCE
    |=> paddr != nbp_pkg::ADDR_CLEARANCE || prdata == {24'd0, $past(pwdata[7:0])})
    else $error("margin readback mismatch");

endmodule

bind node_boundary_point nbp_check u_check (.*);

`default_nettype wire
